/* rtl/skt_pkg.sv */
package skt_pkg;

  // Default sizes of the table
  localparam int CAPACITY_DEF  = 16;
  localparam int KEY_WIDTH_DEF = 32;

  // Operation codes on the kind field
  localparam logic [1:0] KIND_INSERT     = 2'd0;
  localparam logic [1:0] KIND_FIND       = 2'd1;
  localparam logic [1:0] KIND_REMOVE_VAL = 2'd2;
  localparam logic [1:0] KIND_REMOVE_POS = 2'd3;

  // Result status codes
  localparam logic [1:0] STATUS_DONE      = 2'd0;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [1:0] STATUS_BAD_POS   = 2'd2;
  localparam logic [1:0] STATUS_FULL      = 2'd3;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_INS_CHK,
    S_INS_PUT,
    S_SRCH_CHK,
    S_POS_RD,
    S_SHIFT,
    S_RESP
  } ctrl_state_e;

  // Datapath commands, one per cycle
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LATCH,
    CMD_FULL,
    CMD_INS_BEGIN,
    CMD_INS_MOVE,
    CMD_INS_PUT,
    CMD_SCAN_BEGIN,
    CMD_SCAN_NEXT,
    CMD_MISS,
    CMD_HIT,
    CMD_TAKE,
    CMD_POS_BEGIN,
    CMD_BADPOS,
    CMD_SHIFT,
    CMD_LOAD
  } dp_cmd_e;

  // Datapath status seen by the controller
  typedef struct packed {
    logic [1:0] kind;
    logic       full;
    logic       empty;
    logic       pos_ok;
    logic       lt;
    logic       eq;
    logic       idx_one;
    logic       scan_last;
    logic       take_more;
    logic       shift_more;
  } dp_status_t;

endpackage

/* rtl/skt_ctrl.sv */
module skt_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  skt_pkg::dp_status_t sts_i,
  output skt_pkg::dp_cmd_e    cmd_o
);
  import skt_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  assign out_free = !out_valid_q || out_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_START;
      end
      S_START: begin
        case (sts_i.kind)
          KIND_INSERT: begin
            if (sts_i.full) state_d = S_RESP;
            else if (sts_i.empty) state_d = S_INS_PUT;
            else state_d = S_INS_CHK;
          end
          KIND_FIND, KIND_REMOVE_VAL: begin
            state_d = sts_i.empty ? S_RESP : S_SRCH_CHK;
          end
          default: begin
            state_d = sts_i.pos_ok ? S_POS_RD : S_RESP;
          end
        endcase
      end
      S_INS_CHK: begin
        if (sts_i.lt) state_d = S_RESP;
        else if (sts_i.idx_one) state_d = S_INS_PUT;
      end
      S_INS_PUT: state_d = S_RESP;
      S_SRCH_CHK: begin
        if (sts_i.lt) begin
          if (sts_i.scan_last) state_d = S_RESP;
        end else if (sts_i.eq && sts_i.kind == KIND_REMOVE_VAL) begin
          state_d = sts_i.take_more ? S_SHIFT : S_RESP;
        end else begin
          state_d = S_RESP;
        end
      end
      S_POS_RD: state_d = sts_i.take_more ? S_SHIFT : S_RESP;
      S_SHIFT: begin
        if (!sts_i.shift_more) state_d = S_RESP;
      end
      S_RESP: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Command to the datapath
  always_comb begin
    cmd_o = CMD_NONE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) cmd_o = CMD_LATCH;
      end
      S_START: begin
        case (sts_i.kind)
          KIND_INSERT: cmd_o = sts_i.full ? CMD_FULL : CMD_INS_BEGIN;
          KIND_FIND, KIND_REMOVE_VAL: cmd_o = sts_i.empty ? CMD_MISS : CMD_SCAN_BEGIN;
          default: cmd_o = sts_i.pos_ok ? CMD_POS_BEGIN : CMD_BADPOS;
        endcase
      end
      S_INS_CHK: cmd_o = sts_i.lt ? CMD_INS_PUT : CMD_INS_MOVE;
      S_INS_PUT: cmd_o = CMD_INS_PUT;
      S_SRCH_CHK: begin
        if (sts_i.lt) cmd_o = sts_i.scan_last ? CMD_MISS : CMD_SCAN_NEXT;
        else if (sts_i.eq) cmd_o = (sts_i.kind == KIND_FIND) ? CMD_HIT : CMD_TAKE;
        else cmd_o = CMD_MISS;
      end
      S_POS_RD: cmd_o = CMD_TAKE;
      S_SHIFT: cmd_o = CMD_SHIFT;
      S_RESP: begin
        if (out_free) cmd_o = CMD_LOAD;
      end
      default: cmd_o = CMD_NONE;
    endcase
  end

  // Hold the result valid until the receiver takes it
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (state_q == S_RESP && out_free) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // A finished result waits while the output slot is still occupied
  a_resp_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESP && out_valid_q && !out_ready_i) |=> state_q == S_RESP)
    else $error("result left the response state while the output was stalled");

endmodule

/* rtl/skt_dp.sv */
module skt_dp #(
  parameter int CAPACITY  = skt_pkg::CAPACITY_DEF,
  parameter int KEY_WIDTH = skt_pkg::KEY_WIDTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [1:0]          kind_i,
  input  logic [31:0]         key_i,
  input  logic [7:0]          position_i,
  input  skt_pkg::dp_cmd_e    cmd_i,
  output skt_pkg::dp_status_t sts_o,
  output logic [1:0]          status_o,
  output logic                found_o,
  output logic [31:0]         removed_value_o,
  output logic [4:0]          entry_count_o
);
  import skt_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam int XW = CW + 1;
  localparam int PW = (CW > 8) ? CW : 8;

  // Key store, ascending order in its first cnt_q entries
  logic [KEY_WIDTH-1:0] mem [CAPACITY];

  logic [1:0]           kind_q;
  logic [KEY_WIDTH-1:0] key_q;
  logic [7:0]           pos_q;
  logic [CW-1:0]        idx_q, idx_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [KEY_WIDTH-1:0] rd_q;
  logic [1:0]           res_status_q;
  logic                 res_found_q;
  logic [KEY_WIDTH-1:0] res_removed_q;
  logic [1:0]           out_status_q;
  logic                 out_found_q;
  logic [31:0]          out_removed_q;
  logic [4:0]           out_count_q;

  logic [63:0]          key_ext;
  logic [63:0]          rem_ext;
  logic [CW+4:0]        cnt_ext;
  logic [XW-1:0]        idx_x, cnt_x;
  logic [CW-1:0]        pos_idx;
  logic                 pos_ok;
  logic                 take_more, shift_more;
  logic                 ren, we;
  logic [CW-1:0]        raddr, waddr;
  logic [KEY_WIDTH-1:0] wdata;

  assign key_ext = {32'd0, key_i};
  assign rem_ext = 64'(res_removed_q);
  assign cnt_ext = (CW + 5)'(cnt_q);
  assign idx_x   = XW'(idx_q);
  assign cnt_x   = XW'(cnt_q);
  assign pos_idx = CW'(pos_q - 8'd1);
  assign pos_ok  = (pos_q != 8'd0) && (PW'(pos_q) <= PW'(cnt_q));
  assign take_more  = (idx_x + XW'(1)) < cnt_x;
  assign shift_more = (idx_x + XW'(2)) < cnt_x;

  // Status toward the controller
  always_comb begin
    sts_o.kind       = kind_q;
    sts_o.full       = (cnt_q == CW'(CAPACITY));
    sts_o.empty      = (cnt_q == '0);
    sts_o.pos_ok     = pos_ok;
    sts_o.lt         = (rd_q < key_q);
    sts_o.eq         = (rd_q == key_q);
    sts_o.idx_one    = (idx_q == CW'(1));
    sts_o.scan_last  = (idx_x + XW'(1)) == cnt_x;
    sts_o.take_more  = take_more;
    sts_o.shift_more = shift_more;
  end

  // Memory read and write addresses per command
  always_comb begin
    ren   = 1'b0;
    raddr = '0;
    we    = 1'b0;
    waddr = idx_q;
    wdata = rd_q;
    case (cmd_i)
      CMD_INS_BEGIN: begin
        ren   = 1'b1;
        raddr = cnt_q - CW'(1);
      end
      CMD_INS_MOVE: begin
        ren   = 1'b1;
        raddr = idx_q - CW'(2);
        we    = 1'b1;
      end
      CMD_INS_PUT: begin
        we    = 1'b1;
        wdata = key_q;
      end
      CMD_SCAN_BEGIN: begin
        ren   = 1'b1;
        raddr = '0;
      end
      CMD_SCAN_NEXT: begin
        ren   = 1'b1;
        raddr = idx_q + CW'(1);
      end
      CMD_TAKE: begin
        ren   = take_more;
        raddr = idx_q + CW'(1);
      end
      CMD_POS_BEGIN: begin
        ren   = 1'b1;
        raddr = pos_idx;
      end
      CMD_SHIFT: begin
        ren   = shift_more;
        raddr = idx_q + CW'(2);
        we    = 1'b1;
      end
      default: begin
        ren = 1'b0;
      end
    endcase
  end

  // Key memory with registered read data
  always_ff @(posedge clk_i) begin
    if (we) mem[waddr[IW-1:0]] <= wdata;
    if (ren) rd_q <= mem[raddr[IW-1:0]];
  end

  // Walk pointer and entry count
  always_comb begin
    idx_d = idx_q;
    cnt_d = cnt_q;
    case (cmd_i)
      CMD_INS_BEGIN:  idx_d = cnt_q;
      CMD_INS_MOVE:   idx_d = idx_q - CW'(1);
      CMD_INS_PUT:    cnt_d = cnt_q + CW'(1);
      CMD_SCAN_BEGIN: idx_d = '0;
      CMD_SCAN_NEXT:  idx_d = idx_q + CW'(1);
      CMD_POS_BEGIN:  idx_d = pos_idx;
      CMD_TAKE: begin
        if (!take_more) cnt_d = cnt_q - CW'(1);
      end
      CMD_SHIFT: begin
        idx_d = idx_q + CW'(1);
        if (!shift_more) cnt_d = cnt_q - CW'(1);
      end
      default: begin
        idx_d = idx_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      idx_q <= idx_d;
    end
  end

  // Capture the transaction and build the result
  always_ff @(posedge clk_i) begin
    case (cmd_i)
      CMD_LATCH: begin
        kind_q <= kind_i;
        key_q  <= key_ext[KEY_WIDTH-1:0];
        pos_q  <= position_i;
      end
      CMD_FULL: begin
        res_status_q  <= STATUS_FULL;
        res_found_q   <= 1'b0;
        res_removed_q <= '0;
      end
      CMD_INS_PUT: begin
        res_status_q  <= STATUS_DONE;
        res_found_q   <= 1'b0;
        res_removed_q <= '0;
      end
      CMD_MISS: begin
        res_status_q  <= STATUS_NOT_FOUND;
        res_found_q   <= 1'b0;
        res_removed_q <= '0;
      end
      CMD_BADPOS: begin
        res_status_q  <= STATUS_BAD_POS;
        res_found_q   <= 1'b0;
        res_removed_q <= '0;
      end
      CMD_HIT: begin
        res_status_q  <= STATUS_DONE;
        res_found_q   <= 1'b1;
        res_removed_q <= '0;
      end
      CMD_TAKE: begin
        res_status_q  <= STATUS_DONE;
        res_found_q   <= 1'b1;
        res_removed_q <= rd_q;
      end
      CMD_LOAD: begin
        out_status_q  <= res_status_q;
        out_found_q   <= res_found_q;
        out_removed_q <= rem_ext[31:0];
        out_count_q   <= cnt_ext[4:0];
      end
      default: begin
        res_found_q <= res_found_q;
      end
    endcase
  end

  assign status_o        = out_status_q;
  assign found_o         = out_found_q;
  assign removed_value_o = out_removed_q;
  assign entry_count_o   = out_count_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_put_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i == CMD_INS_PUT |=> cnt_q == $past(cnt_q) + CW'(1))
    else $error("insert did not advance the entry count");

  a_full_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i == CMD_FULL |-> (cnt_q == CW'(CAPACITY)) ##1 $stable(cnt_q))
    else $error("full rejection with room left or count changed");

endmodule

/* rtl/sorted_key_table_top.sv */
// Sorted key table: holds up to CAPACITY unsigned keys in ascending order.
// Input channel (in_valid_i/in_ready_o) carries one operation per
// transaction: insert, find, remove by value or remove at a 1-based
// position. Output channel (out_valid_o/out_ready_i) returns one result
// per transaction: status, found flag, removed key and entry count.
// Keys live in a single memory with one write and one registered read per
// cycle; the controller walks it one entry per cycle, scanning entries
// (find, remove by value) or moving them (insert, removal). Rejected
// inserts, bad positions and lookups in an empty table finish without a walk.
// One operation is in work at a time; in_ready_o rises again the cycle after
// the result is written to the output register, so the block takes no new
// transaction until the earlier result is in the output register.
// The next transaction is accepted while a result waits; its own result
// is held inside until the receiver takes the earlier one.
// Reset clears the entry count and the handshake state; the key memory
// needs no clearing pass since only counted entries are ever used.
module sorted_key_table_top #(
  parameter int CAPACITY  = skt_pkg::CAPACITY_DEF,
  parameter int KEY_WIDTH = skt_pkg::KEY_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [31:0] key_i,
  input  logic [7:0]  position_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic        found_o,
  output logic [31:0] removed_value_o,
  output logic [4:0]  entry_count_o
);
  import skt_pkg::*;

  dp_cmd_e    cmd;
  dp_status_t sts;

  // Sequence the operation
  skt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Key memory, walk pointer and result registers
  skt_dp #(
    .CAPACITY  (CAPACITY),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .kind_i          (kind_i),
    .key_i           (key_i),
    .position_i      (position_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .status_o        (status_o),
    .found_o         (found_o),
    .removed_value_o (removed_value_o),
    .entry_count_o   (entry_count_o)
  );

endmodule

/* sim/sorted_key_table_top_tb.sv */
module sorted_key_table_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import skt_pkg::*;

  localparam int CAPACITY     = CAPACITY_DEF;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 60;
  localparam int HOLD_CYCLES  = 250;

  typedef struct packed {
    logic [1:0]  status;
    logic        found;
    logic [31:0] removed_value;
    logic [4:0]  entry_count;
  } table_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  kind_i;
  logic [31:0] key_i;
  logic [7:0]  position_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [1:0]  status_o;
  logic        found_o;
  logic [31:0] removed_value_o;
  logic [4:0]  entry_count_o;

  // Mirror of the table contents, kept in ascending order
  logic [31:0]   held_keys[$];
  table_result_t pending_results[$];
  logic [31:0]   key_pool[8];
  int            mismatch_count = 0;
  bit            sender_burst   = 1'b0;
  int            hold_off_cycles = 0;

  sorted_key_table_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .kind_i         (kind_i),
    .key_i          (key_i),
    .position_i     (position_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .found_o        (found_o),
    .removed_value_o(removed_value_o),
    .entry_count_o  (entry_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Apply one operation to the mirrored table and return its result
  function automatic table_result_t apply_table_op(input logic [1:0] kind,
                                                   input logic [31:0] key,
                                                   input logic [7:0] position);
    table_result_t res;
    int idx;
    res = '0;
    res.status = STATUS_DONE;
    // first entry not less than the key
    idx = 0;
    while (idx < held_keys.size() && held_keys[idx] < key) idx++;
    case (kind)
      KIND_INSERT: begin
        if (held_keys.size() >= CAPACITY) begin
          res.status = STATUS_FULL;
        end else begin
          held_keys.insert(idx, key);
        end
      end
      KIND_FIND, KIND_REMOVE_VAL: begin
        if (idx < held_keys.size() && held_keys[idx] == key) begin
          res.found = 1'b1;
          if (kind == KIND_REMOVE_VAL) begin
            res.removed_value = held_keys[idx];
            held_keys.delete(idx);
          end
        end else begin
          res.status = STATUS_NOT_FOUND;
        end
      end
      default: begin
        if (position >= 1 && position <= held_keys.size()) begin
          res.found = 1'b1;
          res.removed_value = held_keys[position - 1];
          held_keys.delete(position - 1);
        end else begin
          res.status = STATUS_BAD_POS;
        end
      end
    endcase
    res.entry_count = 5'(held_keys.size());
    return res;
  endfunction

  // Offer one operation, wait for the transaction, then record its expected result
  task automatic send_op(input logic [1:0] kind, input logic [31:0] key,
                         input logic [7:0] position);
    int gap;
    gap = sender_burst ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= kind;
    key_i      <= key;
    position_i <= position;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(apply_table_op(kind, key, position));
  endtask

  // Favor keys already held or from a small pool so lookups hit and duplicates form
  function automatic logic [31:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40 && held_keys.size() > 0) return held_keys[$urandom_range(0, held_keys.size() - 1)];
    if (r < 75) return key_pool[$urandom_range(0, 7)];
    if (r < 85) return $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
    return $urandom();
  endfunction

  task automatic test_empty_table();
    send_op(KIND_FIND, 32'd7, 8'd0);
    send_op(KIND_REMOVE_VAL, 32'd7, 8'd0);
    send_op(KIND_REMOVE_POS, 32'd0, 8'd1);
  endtask

  task automatic test_key_extremes();
    send_op(KIND_INSERT, 32'hFFFF_FFFF, 8'd0);
    send_op(KIND_INSERT, 32'h0, 8'd0);
    send_op(KIND_INSERT, 32'h0, 8'd0);
    send_op(KIND_INSERT, 32'd5, 8'd0);
    send_op(KIND_FIND, 32'h0, 8'd0);
    send_op(KIND_FIND, 32'd6, 8'd0);
    send_op(KIND_REMOVE_VAL, 32'hFFFF_FFFF, 8'd0);
    // a removed zero key still reports found
    send_op(KIND_REMOVE_VAL, 32'h0, 8'd0);
    send_op(KIND_REMOVE_POS, 32'hFFFF_FFFF, 8'd0);
    send_op(KIND_REMOVE_POS, 32'h0, 8'd255);
    send_op(KIND_REMOVE_POS, 32'h0, 8'd3);
    send_op(KIND_REMOVE_POS, 32'h0, 8'd2);
  endtask

  task automatic test_full_table();
    while (held_keys.size() < CAPACITY) send_op(KIND_INSERT, $urandom(), 8'd0);
    send_op(KIND_INSERT, 32'd9, 8'd0);
    send_op(KIND_FIND, held_keys[CAPACITY - 1], 8'd0);
    send_op(KIND_REMOVE_POS, 32'h0, 8'(CAPACITY));
  endtask

  // Stall the output long enough that the block backs up into its input
  task automatic test_output_stall();
    sender_burst = 1'b1;
    hold_off_cycles = HOLD_CYCLES;
    repeat (20) send_op(2'($urandom_range(0, 3)), pick_key(), 8'($urandom_range(0, 4)));
    sender_burst = 1'b0;
  endtask

  task automatic test_random_mix(input int num_ops);
    int r, ins_pct, find_pct, rmv_pct, count;
    logic [1:0] kind;
    logic [7:0] position;
    ins_pct = 30;
    find_pct = 30;
    rmv_pct = 20;
    for (int n = 0; n < num_ops; n++) begin
      // new phase: refresh the key pool, growth bias and gap mode
      if (n % 60 == 0) begin
        foreach (key_pool[i]) key_pool[i] = $urandom_range(0, 1) ? $urandom_range(0, 20) : $urandom();
        sender_burst = ($urandom_range(0, 3) == 0);
        case ($urandom_range(0, 2))
          0: begin
            ins_pct = 55; find_pct = 15; rmv_pct = 15;
          end
          1: begin
            ins_pct = 20; find_pct = 15; rmv_pct = 35;
          end
          default: begin
            ins_pct = 30; find_pct = 30; rmv_pct = 20;
          end
        endcase
      end
      r = $urandom_range(0, 99);
      if (r < ins_pct) kind = KIND_INSERT;
      else if (r < ins_pct + find_pct) kind = KIND_FIND;
      else if (r < ins_pct + find_pct + rmv_pct) kind = KIND_REMOVE_VAL;
      else kind = KIND_REMOVE_POS;
      count = held_keys.size();
      r = $urandom_range(0, 99);
      if (count > 0 && r < 75) position = 8'($urandom_range(1, count));
      else if (r < 85) position = 8'(count + 1);
      else if (r < 90) position = 8'd0;
      else position = 8'($urandom_range(0, 255));
      send_op(kind, pick_key(), position);
    end
    sender_burst = 1'b0;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Compare each result transaction with the oldest expectation
  always @(posedge clk_i) begin
    table_result_t want;
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_ready_i === 1'b1) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0h count %0h",
                 $time, status_o, entry_count_o);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", 32'(want.status), 32'(status_o));
        check_field("found", 32'(want.found), 32'(found_o));
        check_field("removed_value", want.removed_value, removed_value_o);
        check_field("entry_count", 32'(want.entry_count), 32'(entry_count_o));
      end
    end
  end

  // Output side: random stalls, stretches without stalls, one long hold-off
  initial begin
    int stall;
    bit receiver_burst;
    receiver_burst = 1'b0;
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_off_cycles > 0) begin
        out_ready_i <= 1'b0;
        repeat (hold_off_cycles) @(posedge clk_i);
        hold_off_cycles = 0;
      end else begin
        if ($urandom_range(0, 29) == 0) receiver_burst = !receiver_burst;
        stall = receiver_burst ? 0 : $urandom_range(0, 19);
        if (stall > 0) begin
          out_ready_i <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
    end
  end

  // End the run when no transaction happens on either channel for too long
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i === 1'b1 && in_ready_o === 1'b1) ||
          (out_valid_o === 1'b1 && out_ready_i === 1'b1)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    kind_i     <= KIND_INSERT;
    key_i      <= 32'h0;
    position_i <= 8'h0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_table();
    test_key_extremes();
    test_full_table();
    test_output_stall();
    test_random_mix(1500);
    in_valid_i <= 1'b0;

    // drain outstanding results, then watch for stray ones
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

/* sim.f */
rtl/skt_pkg.sv
rtl/skt_ctrl.sv
rtl/skt_dp.sv
rtl/sorted_key_table_top.sv
sim/sorted_key_table_top_tb.sv
